FILE: src/mmecm_pkg.sv
// Shared types, constants and defaults for the min/max envelope column mapper.
// Used by every module in src except mmecm_divider; depends on nothing.
package mmecm_pkg;

    // Fixed field widths of the register set and the result transaction.
    localparam int AMP_BITS   = 16;
    localparam int PW_BITS    = 11;
    localparam int FPL_BITS   = 16;
    localparam int CHAN_BITS  = 4;
    localparam int LINE_BITS  = 32;
    localparam int COL_BITS   = 10;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 5;

    // Parameter defaults for the top level.
    localparam int DEF_MAX_COLUMNS  = 1024;
    localparam int DEF_MAX_CHANNELS = 8;
    localparam int DEF_SAMPLE_BITS  = 16;

    // Register reset values.
    localparam logic signed [AMP_BITS-1:0] RST_Y_MIN = 16'sh8000;
    localparam logic signed [AMP_BITS-1:0] RST_Y_MAX = 16'sh7FFF;
    localparam logic [PW_BITS-1:0]         RST_PLOT_WIDTH = 11'd49;
    localparam logic [FPL_BITS-1:0]        RST_FRAMES_PER_LINE = 16'd10000;
    localparam logic [CHAN_BITS-1:0]       RST_CHANNEL_COUNT = 4'd1;
    localparam logic [LINE_BITS-1:0]       RST_START_INDEX = 32'd0;

    typedef enum logic [2:0] {
        REG_Y_MIN,
        REG_Y_MAX,
        REG_PLOT_WIDTH,
        REG_FRAMES_PER_LINE,
        REG_CHANNEL_COUNT,
        REG_START_INDEX
    } reg_idx_t;

    typedef struct packed {
        logic signed [AMP_BITS-1:0] y_min;
        logic signed [AMP_BITS-1:0] y_max;
        logic [PW_BITS-1:0]         plot_width;
        logic [FPL_BITS-1:0]        frames_per_line;
        logic [CHAN_BITS-1:0]       channel_count;
        logic [LINE_BITS-1:0]       start_index;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_LO,
        ST_DIV_LO,
        ST_MUL_HI,
        ST_DIV_HI,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic prep;
        logic sel_hi;
        logic div_start;
        logic save_lo;
        logic save_hi;
        logic load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic start_calc;
        logic div_done;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: src/mmecm_regs.sv
// APB-style configuration register file of the envelope column mapper.
// Depends on mmecm_pkg for the register layout and reset values.
module mmecm_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mmecm_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [mmecm_pkg::DATA_BITS-1:0]   pwdata,
    output logic [mmecm_pkg::DATA_BITS-1:0]   prdata,
    output mmecm_pkg::cfg_t                   cfg
);
    import mmecm_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.y_min           <= RST_Y_MIN;
            cfg_reg.y_max           <= RST_Y_MAX;
            cfg_reg.plot_width      <= RST_PLOT_WIDTH;
            cfg_reg.frames_per_line <= RST_FRAMES_PER_LINE;
            cfg_reg.channel_count   <= RST_CHANNEL_COUNT;
            cfg_reg.start_index     <= RST_START_INDEX;
        end else if (wr_en) begin
            case (idx)
                REG_Y_MIN:           cfg_reg.y_min <= pwdata[AMP_BITS-1:0];
                REG_Y_MAX:           cfg_reg.y_max <= pwdata[AMP_BITS-1:0];
                REG_PLOT_WIDTH:      cfg_reg.plot_width <= pwdata[PW_BITS-1:0];
                REG_FRAMES_PER_LINE: cfg_reg.frames_per_line <= pwdata[FPL_BITS-1:0];
                REG_CHANNEL_COUNT:   cfg_reg.channel_count <= pwdata[CHAN_BITS-1:0];
                REG_START_INDEX:     cfg_reg.start_index <= pwdata[LINE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_Y_MIN:
                prdata = {{(DATA_BITS-AMP_BITS){1'b0}}, cfg_reg.y_min};
            REG_Y_MAX:
                prdata = {{(DATA_BITS-AMP_BITS){1'b0}}, cfg_reg.y_max};
            REG_PLOT_WIDTH:
                prdata = {{(DATA_BITS-PW_BITS){1'b0}}, cfg_reg.plot_width};
            REG_FRAMES_PER_LINE:
                prdata = {{(DATA_BITS-FPL_BITS){1'b0}}, cfg_reg.frames_per_line};
            REG_CHANNEL_COUNT:
                prdata = {{(DATA_BITS-CHAN_BITS){1'b0}}, cfg_reg.channel_count};
            REG_START_INDEX:
                prdata = cfg_reg.start_index;
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: src/mmecm_ctrl.sv
// Sequencing state machine of the envelope column mapper.
// Depends on mmecm_pkg for the state, command and status types.
module mmecm_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mmecm_pkg::dp_stat_t   stat,
    output mmecm_pkg::ctrl_cmd_t  cmd
);
    import mmecm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (stat.start_calc) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_DIV_LO;
            ST_DIV_LO: begin
                if (stat.div_done) begin
                    state_next = ST_MUL_HI;
                end
            end
            ST_MUL_HI: state_next = ST_DIV_HI;
            ST_DIV_HI: begin
                if (stat.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.take = 1'b1;
            ST_PREP:   cmd.prep = 1'b1;
            ST_MUL_LO: cmd.div_start = 1'b1;
            ST_DIV_LO: cmd.save_lo = stat.div_done;
            ST_MUL_HI: begin
                cmd.sel_hi    = 1'b1;
                cmd.div_start = 1'b1;
            end
            ST_DIV_HI: cmd.save_hi = stat.div_done;
            ST_FINISH: cmd.load_out = stat.out_free;
            default: begin
            end
        endcase
    end

endmodule

FILE: src/mmecm_divider.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
// Self-contained; used by mmecm_datapath.
module mmecm_divider #(
    parameter int NUM_BITS = 27,
    parameter int DEN_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_BITS-1:0] dividend,
    input  logic [DEN_BITS-1:0] divisor,
    output logic [NUM_BITS-1:0] quotient,
    output logic                done
);
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] num_reg;
    logic [NUM_BITS-1:0] num_next;
    logic [DEN_BITS-1:0] rem_reg;
    logic [DEN_BITS-1:0] rem_next;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                fits;

    // The dividend shifts out at the top while quotient bits shift in below.
    assign trial    = {rem_reg, num_reg[NUM_BITS-1]};
    assign fits     = trial >= {1'b0, divisor};
    assign diff     = trial - {1'b0, divisor};
    assign rem_next = fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    assign num_next = {num_reg[NUM_BITS-2:0], fits};

    assign quotient = num_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

endmodule

FILE: src/mmecm_datapath.sv
// Datapath: group tracking, clamping, column scaling and the result register.
// Depends on mmecm_pkg and instantiates mmecm_divider.
module mmecm_datapath #(
    parameter int MAX_COLUMNS  = mmecm_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_CHANNELS = mmecm_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mmecm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mmecm_pkg::cfg_t                      cfg,
    input  mmecm_pkg::ctrl_cmd_t                 cmd,
    output mmecm_pkg::dp_stat_t                  stat,
    input  logic                                 s_valid,
    input  logic signed [SAMPLE_BITS-1:0]        s_sample,
    input  logic                                 s_last_in_range,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mmecm_pkg::LINE_BITS-1:0]      m_line_start,
    output logic [mmecm_pkg::COL_BITS-1:0]       m_left_column,
    output logic [mmecm_pkg::COL_BITS-1:0]       m_right_column
);
    import mmecm_pkg::*;

    localparam int EW  = (SAMPLE_BITS > AMP_BITS) ? SAMPLE_BITS : AMP_BITS;
    localparam int EW1 = EW + 1;
    localparam int AW1 = AMP_BITS + 1;
    localparam int WW  = $clog2(MAX_COLUMNS + 1);
    localparam int NW  = EW + WW;
    localparam int CPW = $clog2(MAX_CHANNELS + 1);
    localparam int OW  = (WW > COL_BITS) ? WW : COL_BITS;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // Effective configuration after range limiting.
    logic [CPW-1:0]      chans_eff;
    logic [FPL_BITS-1:0] fpl_eff;
    logic [WW-1:0]       w_eff;

    always_comb begin
        if (cfg.channel_count == '0) begin
            chans_eff = CPW'(1);
        end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
            chans_eff = CPW'(MAX_CHANNELS);
        end else begin
            chans_eff = CPW'(cfg.channel_count);
        end
        if (cfg.plot_width == '0) begin
            w_eff = WW'(1);
        end else if (int'(cfg.plot_width) > MAX_COLUMNS) begin
            w_eff = WW'(MAX_COLUMNS);
        end else begin
            w_eff = WW'(cfg.plot_width);
        end
        fpl_eff = (cfg.frames_per_line == '0) ? FPL_BITS'(1) : cfg.frames_per_line;
    end

    // Running group state.
    logic signed [SAMPLE_BITS-1:0] run_low_reg;
    logic signed [SAMPLE_BITS-1:0] run_high_reg;
    logic [CPW-1:0]                chan_pos_reg;
    logic [FPL_BITS-1:0]           frame_pos_reg;
    logic [LINE_BITS-1:0]          frames_done_reg;

    logic signed [SAMPLE_BITS-1:0] low_next;
    logic signed [SAMPLE_BITS-1:0] high_next;
    logic [CPW-1:0]                chan_inc;
    logic [FPL_BITS-1:0]           frame_inc;
    logic [FPL_BITS-1:0]           frame_next;
    logic                          frame_wrap;
    logic                          close;
    logic                          accept;
    logic                          capture;

    assign accept     = s_valid & cmd.take;
    assign low_next   = (s_sample < run_low_reg) ? s_sample : run_low_reg;
    assign high_next  = (s_sample > run_high_reg) ? s_sample : run_high_reg;
    assign chan_inc   = chan_pos_reg + CPW'(1);
    assign frame_wrap = (chan_inc >= chans_eff) | s_last_in_range;
    assign frame_inc  = frame_pos_reg + FPL_BITS'(1);
    assign frame_next = frame_wrap ? frame_inc : frame_pos_reg;
    // A position left beyond a lowered limit closes the group on any sample.
    assign close      = (frame_next >= fpl_eff) | s_last_in_range;
    assign capture    = accept & close;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_low_reg     <= SAMPLE_MAX;
            run_high_reg    <= SAMPLE_MIN;
            chan_pos_reg    <= '0;
            frame_pos_reg   <= '0;
            frames_done_reg <= '0;
        end else if (accept) begin
            if (close) begin
                run_low_reg   <= SAMPLE_MAX;
                run_high_reg  <= SAMPLE_MIN;
                chan_pos_reg  <= '0;
                frame_pos_reg <= '0;
                frames_done_reg <= s_last_in_range ? '0 :
                                   frames_done_reg + LINE_BITS'(frame_next);
            end else begin
                run_low_reg   <= low_next;
                run_high_reg  <= high_next;
                chan_pos_reg  <= frame_wrap ? '0 : chan_inc;
                frame_pos_reg <= frame_next;
            end
        end
    end

    // Closed group held for the column computation.
    logic signed [SAMPLE_BITS-1:0] grp_low_reg;
    logic signed [SAMPLE_BITS-1:0] grp_high_reg;
    logic [LINE_BITS-1:0]          line_work_reg;

    always_ff @(posedge aclk) begin
        if (capture) begin
            grp_low_reg   <= low_next;
            grp_high_reg  <= high_next;
            line_work_reg <= cfg.start_index + frames_done_reg;
        end
    end

    // Clamp to the plot edges and form the offsets from the left edge.
    logic signed [EW-1:0]       lo_ext;
    logic signed [EW-1:0]       hi_ext;
    logic signed [EW-1:0]       low_ext;
    logic signed [EW-1:0]       high_ext;
    logic signed [EW-1:0]       v_lo;
    logic signed [EW-1:0]       v_hi;
    logic signed [EW:0]         d_lo;
    logic signed [EW:0]         d_hi;
    logic signed [AMP_BITS:0]   r_diff;
    logic [EW-1:0]              dlo_reg;
    logic [EW-1:0]              dhi_reg;
    logic [AMP_BITS-1:0]        range_reg;
    logic                       zero_range_reg;

    assign lo_ext   = EW'(cfg.y_min);
    assign hi_ext   = EW'(cfg.y_max);
    assign low_ext  = EW'(grp_low_reg);
    assign high_ext = EW'(grp_high_reg);
    assign v_lo     = (low_ext < lo_ext) ? lo_ext : low_ext;
    assign v_hi     = (high_ext > hi_ext) ? hi_ext : high_ext;
    assign d_lo     = EW1'(v_lo) - EW1'(lo_ext);
    assign d_hi     = EW1'(v_hi) - EW1'(lo_ext);
    assign r_diff   = AW1'(cfg.y_max) - AW1'(cfg.y_min);

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            dlo_reg        <= d_lo[EW-1:0];
            // An offset below the left edge maps to column zero.
            dhi_reg        <= d_hi[EW] ? '0 : d_hi[EW-1:0];
            range_reg      <= r_diff[AMP_BITS] ? AMP_BITS'(-r_diff) : r_diff[AMP_BITS-1:0];
            zero_range_reg <= (r_diff == '0);
        end
    end

    // One shared multiplier feeds the divider's dividend register.
    logic [EW-1:0] mul_a;
    logic [NW-1:0] product;
    logic [NW-1:0] quotient;
    logic          div_done;

    assign mul_a   = cmd.sel_hi ? dhi_reg : dlo_reg;
    assign product = NW'(mul_a) * NW'(w_eff);

    mmecm_divider #(
        .NUM_BITS (NW),
        .DEN_BITS (AMP_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (product),
        .divisor  (range_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    logic [NW-1:0] q_lo_reg;
    logic [NW-1:0] q_hi_reg;

    always_ff @(posedge aclk) begin
        if (cmd.save_lo) begin
            q_lo_reg <= quotient;
        end
        if (cmd.save_hi) begin
            q_hi_reg <= quotient;
        end
    end

    // Cap the right column at the last column and keep left from passing it; a zero range gives zero for both.
    logic [WW-1:0] right_col;
    logic [WW-1:0] left_col;
    logic [OW-1:0] right_wide;
    logic [OW-1:0] left_wide;

    always_comb begin
        right_col = (q_hi_reg >= NW'(w_eff)) ? (w_eff - WW'(1)) : WW'(q_hi_reg);
        left_col  = (q_lo_reg > NW'(right_col)) ? right_col : WW'(q_lo_reg);
        if (zero_range_reg) begin
            right_col = '0;
            left_col  = '0;
        end
    end

    assign right_wide = OW'(right_col);
    assign left_wide  = OW'(left_col);

    // Result register.
    logic                 m_valid_reg;
    logic [LINE_BITS-1:0] m_line_reg;
    logic [COL_BITS-1:0]  m_left_reg;
    logic [COL_BITS-1:0]  m_right_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_line_reg  <= line_work_reg;
            m_left_reg  <= left_wide[COL_BITS-1:0];
            m_right_reg <= right_wide[COL_BITS-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_line_start   = m_line_reg;
    assign m_left_column  = m_left_reg;
    assign m_right_column = m_right_reg;

    assign stat.start_calc = capture;
    assign stat.div_done   = div_done;
    assign stat.out_free   = ~m_valid_reg | m_ready;

endmodule

FILE: src/minmax_envelope_column_mapper_top.sv
// Top level of the min/max envelope column mapper; uses mmecm_pkg and all src modules.
// A sample that does not close a group is taken one per cycle while s_ready is high.
// A closing sample keeps s_ready low until its result is loaded into the result register;
// the columns come from the bit-serial divider run twice, low column then high, and the
// load is held back while an earlier result waits untaken.
// Synchronous active-low reset clears the group state and restores register defaults.
module minmax_envelope_column_mapper_top #(
    parameter int MAX_COLUMNS  = mmecm_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_CHANNELS = mmecm_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = mmecm_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mmecm_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [mmecm_pkg::DATA_BITS-1:0]    pwdata,
    output logic [mmecm_pkg::DATA_BITS-1:0]    prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    input  logic                               s_last_in_range,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mmecm_pkg::LINE_BITS-1:0]    m_line_start,
    output logic [mmecm_pkg::COL_BITS-1:0]     m_left_column,
    output logic [mmecm_pkg::COL_BITS-1:0]     m_right_column
);
    import mmecm_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign pready  = 1'b1;
    assign s_ready = cmd.take;

    mmecm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mmecm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .cmd     (cmd)
    );

    mmecm_datapath #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .MAX_CHANNELS (MAX_CHANNELS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .s_valid         (s_valid),
        .s_sample        (s_sample),
        .s_last_in_range (s_last_in_range),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_line_start    (m_line_start),
        .m_left_column   (m_left_column),
        .m_right_column  (m_right_column)
    );

    // A closing transaction must stop the input while its columns are computed.
    a_close_stalls_input: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.start_calc |=> !s_ready)
        else $error("input accepted right after a group closed");

    // The divider may only finish while the controller waits for it.
    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.div_done |-> (cmd.save_lo || cmd.save_hi))
        else $error("divider finished outside a wait state");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("result register overwritten");

    // Without output masking, the left column never passes the right one.
    a_columns_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (MAX_COLUMNS <= (1 << COL_BITS))) |-> (m_left_column <= m_right_column))
        else $error("left column beyond right column");

endmodule
